// File: sv/cp3_pkg.sv
// Shared types, constants and helper functions for the three-axis cascaded PID block.
package cp3_pkg;

  // Field and datapath widths.
  localparam int SIG_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = GAIN_W / 2;
  localparam int SIG_FRAC  = 16;
  localparam int OUT_SHIFT = GAIN_FRAC + 1;
  localparam int REG_W     = 48;
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int DRIVE_W   = 27;
  localparam int INTEG_W   = 23;
  localparam int OPB_W     = SIG_W + 1;
  localparam int PROD_W    = GAIN_W + OPB_W;
  localparam int ACC_W     = PROD_W + 2;

  typedef logic signed [SIG_W-1:0]   sig_t;
  typedef logic signed [OPB_W-1:0]   opb_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;
  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic [REG_W-1:0]          reg_t;
  typedef logic [1:0]                axis_t;

  // Limits in Q16.16.
  localparam integ_t OUT_ICLAMP  = 23'sd1310720;
  localparam integ_t IN_ICLAMP   = 23'sd1966080;
  localparam sig_t   SEP_LIMIT   = 32'sd3276;
  localparam drive_t DRIVE_LIMIT = 27'sd39321600;
  localparam sig_t   SIG_MAX     = 32'sh7FFF_FFFF;
  localparam sig_t   SIG_MIN     = 32'sh8000_0000;
  localparam reg_t   SETPOINTS_RESET = 48'h0000_FF00_0000;
  localparam axis_t  AXIS_LAST   = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINTS,
    REG_OUTER_X,
    REG_OUTER_Y,
    REG_OUTER_Z,
    REG_INNER_X,
    REG_INNER_Y,
    REG_INNER_Z
  } reg_idx_t;

  // Gain fields inside one gain register.
  typedef enum logic [1:0] {
    FLD_KP,
    FLD_KI,
    FLD_KD
  } gain_fld_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MP,
    S_MD,
    S_MI,
    S_ACC,
    S_OUT,
    S_DONE
  } state_t;

  // Extract one signed Q8.8 field from a packed register.
  function automatic gain_t get_field(reg_t r, logic [1:0] k);
    return r[k*GAIN_W +: GAIN_W];
  endfunction

  // Saturate a one-bit-wider difference to the signal width.
  function automatic sig_t sat_sig(opb_t v);
    if (v > opb_t'(SIG_MAX)) begin
      return SIG_MAX;
    end else if (v < opb_t'(SIG_MIN)) begin
      return SIG_MIN;
    end
    return sig_t'(v);
  endfunction

  // Saturate a shifted accumulator to the signal width.
  function automatic sig_t sat_acc(acc_t v);
    if (v > acc_t'(SIG_MAX)) begin
      return SIG_MAX;
    end else if (v < acc_t'(SIG_MIN)) begin
      return SIG_MIN;
    end
    return sig_t'(v);
  endfunction

  // Clamp a shifted accumulator to the drive range.
  function automatic drive_t clamp_drive(acc_t v);
    if (v > acc_t'(DRIVE_LIMIT)) begin
      return DRIVE_LIMIT;
    end else if (v < -acc_t'(DRIVE_LIMIT)) begin
      return -DRIVE_LIMIT;
    end
    return drive_t'(v);
  endfunction

  // Clamp an integral sum to plus or minus a limit.
  function automatic integ_t clamp_integ(opb_t v, integ_t lim);
    if (v > opb_t'(lim)) begin
      return lim;
    end else if (v < -opb_t'(lim)) begin
      return -lim;
    end
    return integ_t'(v);
  endfunction

endpackage

// File: sv/cascaded_pid_three_axis_top.sv
// Three-axis cascaded PID controller built around one shared multiplier.
//
//   Channel | Signals                                     | Direction
//   --------+---------------------------------------------+----------
//   input   | in_valid, in_ready, angle_x/y/z, rate_x/y/z | in
//   output  | out_valid, out_ready, drive_x/y/z,          | out
//           | rate_target_x/y/z                           |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
// Each item runs six PID loops (outer then inner, per axis) on one 16 x 33 multiplier
// and accumulator, each loop stepping through error, P, D and I multiplies, accumulate
// and output. A new item is taken only after the last result is loaded for output.
// Reset loads the register defaults and clears all integrals and last errors.
// A result waiting on out_ready does not block the next input transfer; only
// handing over a fresh result waits for the output register to free up.
module cascaded_pid_three_axis_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cp3_pkg::sig_t                       angle_x,
  input  cp3_pkg::sig_t                       angle_y,
  input  cp3_pkg::sig_t                       angle_z,
  input  cp3_pkg::sig_t                       rate_x,
  input  cp3_pkg::sig_t                       rate_y,
  input  cp3_pkg::sig_t                       rate_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cp3_pkg::drive_t                     drive_x,
  output cp3_pkg::drive_t                     drive_y,
  output cp3_pkg::drive_t                     drive_z,
  output cp3_pkg::sig_t                       rate_target_x,
  output cp3_pkg::sig_t                       rate_target_y,
  output cp3_pkg::sig_t                       rate_target_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cp3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  cp3_pkg::reg_t                       cfg_data
);

  cp3_pkg::state_t state, state_next;

  cp3_pkg::reg_t   cfg_regs [cp3_pkg::NUM_REGS];
  cp3_pkg::sig_t   angle_q [3];
  cp3_pkg::sig_t   rate_q [3];
  cp3_pkg::sig_t   tgt_w [3];
  cp3_pkg::drive_t drv_w [3];
  cp3_pkg::integ_t outer_integral [3];
  cp3_pkg::integ_t inner_integral [3];
  cp3_pkg::sig_t   outer_last_error [3];
  cp3_pkg::sig_t   inner_last_error [3];

  cp3_pkg::axis_t  axis;
  logic            loop_sel;
  cp3_pkg::sig_t   err;
  logic            sep_flag;
  cp3_pkg::prod_t  prod;
  cp3_pkg::acc_t   acc;

  logic                          load_out;
  logic [cp3_pkg::CFG_IDX_W-1:0] gain_idx;
  cp3_pkg::reg_t                 gain_reg;
  cp3_pkg::gain_fld_t            fld_sel;
  cp3_pkg::gain_t                op_gain;
  cp3_pkg::opb_t                 op_b;
  cp3_pkg::prod_t                mult;
  cp3_pkg::integ_t               cur_integ;
  cp3_pkg::sig_t                 cur_last;
  cp3_pkg::opb_t                 target_ext;
  cp3_pkg::opb_t                 meas_ext;
  cp3_pkg::sig_t                 err_next;
  cp3_pkg::integ_t               integ_next;
  cp3_pkg::acc_t                 acc_shifted;
  cp3_pkg::acc_t                 prod_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == cp3_pkg::S_IDLE);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cp3_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: six steps per loop, two loops per axis, three axes.
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      cp3_pkg::S_IDLE: if (in_valid) state_next = cp3_pkg::S_ERR;
      cp3_pkg::S_ERR:  state_next = cp3_pkg::S_MP;
      cp3_pkg::S_MP:   state_next = cp3_pkg::S_MD;
      cp3_pkg::S_MD:   state_next = cp3_pkg::S_MI;
      cp3_pkg::S_MI:   state_next = cp3_pkg::S_ACC;
      cp3_pkg::S_ACC:  state_next = cp3_pkg::S_OUT;
      cp3_pkg::S_OUT: begin
        if (loop_sel && axis == cp3_pkg::AXIS_LAST) begin
          state_next = cp3_pkg::S_DONE;
        end else begin
          state_next = cp3_pkg::S_ERR;
        end
      end
      cp3_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = cp3_pkg::S_IDLE;
        end
      end
      default: state_next = cp3_pkg::S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    gain_idx = loop_sel ? (cp3_pkg::CFG_IDX_W'(cp3_pkg::REG_INNER_X) + {1'b0, axis})
                        : (cp3_pkg::CFG_IDX_W'(cp3_pkg::REG_OUTER_X) + {1'b0, axis});
    gain_reg  = cfg_regs[gain_idx];
    cur_integ = loop_sel ? inner_integral[axis] : outer_integral[axis];
    cur_last  = loop_sel ? inner_last_error[axis] : outer_last_error[axis];
    unique case (state)
      cp3_pkg::S_MD: begin
        fld_sel = cp3_pkg::FLD_KD;
        op_b    = cp3_pkg::opb_t'(err) - cp3_pkg::opb_t'(cur_last);
      end
      cp3_pkg::S_MI: begin
        fld_sel = cp3_pkg::FLD_KI;
        op_b    = cp3_pkg::opb_t'(cur_integ);
      end
      default: begin
        fld_sel = cp3_pkg::FLD_KP;
        op_b    = cp3_pkg::opb_t'(err);
      end
    endcase
    op_gain = cp3_pkg::get_field(gain_reg, fld_sel);
    mult    = cp3_pkg::prod_t'(op_gain) * cp3_pkg::prod_t'(op_b);
  end

  // Error, integral update and output scaling.
  always_comb begin
    if (loop_sel) begin
      target_ext = cp3_pkg::opb_t'(tgt_w[axis]);
      meas_ext   = cp3_pkg::opb_t'(rate_q[axis]);
    end else begin
      target_ext = cp3_pkg::opb_t'(cp3_pkg::get_field(cfg_regs[cp3_pkg::REG_SETPOINTS],
                                                      axis))
                   <<< (cp3_pkg::SIG_FRAC - cp3_pkg::GAIN_FRAC);
      meas_ext   = cp3_pkg::opb_t'(angle_q[axis]);
    end
    err_next    = cp3_pkg::sat_sig(target_ext - meas_ext);
    integ_next  = cp3_pkg::clamp_integ(cp3_pkg::opb_t'(cur_integ) + cp3_pkg::opb_t'(err),
                                       loop_sel ? cp3_pkg::IN_ICLAMP : cp3_pkg::OUT_ICLAMP);
    prod_ext    = cp3_pkg::acc_t'(prod);
    acc_shifted = acc >>> cp3_pkg::OUT_SHIFT;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[cp3_pkg::REG_SETPOINTS] <= cp3_pkg::SETPOINTS_RESET;
      for (int i = int'(cp3_pkg::REG_OUTER_X); i < cp3_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < cp3_pkg::CFG_IDX_W'(cp3_pkg::NUM_REGS)) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Loop state: integrals and last errors, cleared on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        outer_integral[i]   <= '0;
        inner_integral[i]   <= '0;
        outer_last_error[i] <= '0;
        inner_last_error[i] <= '0;
      end
    end else begin
      if (state == cp3_pkg::S_MP) begin
        if (loop_sel) begin
          inner_integral[axis] <= integ_next;
        end else begin
          outer_integral[axis] <= integ_next;
        end
      end
      if (state == cp3_pkg::S_MD) begin
        if (loop_sel) begin
          inner_last_error[axis] <= err;
        end else begin
          outer_last_error[axis] <= err;
        end
      end
    end
  end

  // Loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis     <= '0;
      loop_sel <= 1'b0;
    end else if (state == cp3_pkg::S_IDLE) begin
      axis     <= '0;
      loop_sel <= 1'b0;
    end else if (state == cp3_pkg::S_OUT) begin
      if (loop_sel) begin
        loop_sel <= 1'b0;
        if (axis != cp3_pkg::AXIS_LAST) begin
          axis <= axis + 2'd1;
        end
      end else begin
        loop_sel <= 1'b1;
      end
    end
  end

  // Datapath: input capture, multiply, accumulate and loop outputs.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle_q[0] <= angle_x;
      angle_q[1] <= angle_y;
      angle_q[2] <= angle_z;
      rate_q[0]  <= rate_x;
      rate_q[1]  <= rate_y;
      rate_q[2]  <= rate_z;
    end
    unique case (state)
      cp3_pkg::S_ERR: err <= err_next;
      cp3_pkg::S_MP: begin
        prod     <= mult;
        sep_flag <= (err <= cp3_pkg::SEP_LIMIT) && (err >= -cp3_pkg::SEP_LIMIT);
      end
      cp3_pkg::S_MD: begin
        prod <= mult;
        acc  <= prod_ext <<< 1;
      end
      cp3_pkg::S_MI: begin
        prod <= mult;
        acc  <= acc + (prod_ext <<< 1);
      end
      cp3_pkg::S_ACC: begin
        if (sep_flag) begin
          acc <= acc + prod_ext;
        end
      end
      cp3_pkg::S_OUT: begin
        if (loop_sel) begin
          drv_w[axis] <= cp3_pkg::clamp_drive(acc_shifted);
        end else begin
          tgt_w[axis] <= cp3_pkg::sat_acc(acc_shifted);
        end
      end
      default: ;
    endcase
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_x       <= drv_w[0];
      drive_y       <= drv_w[1];
      drive_z       <= drv_w[2];
      rate_target_x <= tgt_w[0];
      rate_target_y <= tgt_w[1];
      rate_target_z <= tgt_w[2];
    end
  end

  // An input transfer always starts the first loop of the x axis.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == cp3_pkg::S_ERR && axis == 2'd0 && !loop_sel))
    else $error("sequencer did not start on the x outer loop");

  // The integrals of the current axis never leave their clamp ranges.
  a_integ: assert property (@(posedge clk) disable iff (rst)
    (outer_integral[axis] <= cp3_pkg::OUT_ICLAMP &&
     outer_integral[axis] >= -cp3_pkg::OUT_ICLAMP &&
     inner_integral[axis] <= cp3_pkg::IN_ICLAMP &&
     inner_integral[axis] >= -cp3_pkg::IN_ICLAMP))
    else $error("integral out of its clamp range");

  // The last inner loop of the z axis hands over to the done state.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == cp3_pkg::S_OUT && loop_sel && axis == cp3_pkg::AXIS_LAST)
    |=> (state == cp3_pkg::S_DONE))
    else $error("sequencer skipped the done state");

  // A delivered x drive stays inside the saturation range.
  a_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_x <= cp3_pkg::DRIVE_LIMIT && drive_x >= -cp3_pkg::DRIVE_LIMIT))
    else $error("drive outside its saturation range");

endmodule

// File: dv/tb_cascaded_pid_three_axis_top.sv
// Self-checking testbench for the three-axis cascaded PID block with integral separation.
module tb_cascaded_pid_three_axis_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cp3_pkg::*;

  // Limits of the fixed-point arithmetic, in Q16.16 apart from the product cap.
  localparam longint SIG_HI        = 64'sd2147483647;
  localparam longint SIG_LO        = -64'sd2147483648;
  localparam longint SEP_BAND      = 64'sd3276;
  localparam longint OUTER_SUM_LIM = 64'sd20 * 64'sd65536;
  localparam longint INNER_SUM_LIM = 64'sd30 * 64'sd65536;
  localparam longint DRIVE_SAT     = 64'sd600 * 64'sd65536;
  localparam longint PROD_CAP      = 64'sh1000_0000_0000_0000;
  localparam reg_t   SP_AT_RESET   = 48'h0000_FF00_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 8000;
  localparam int MAX_REPORTS = 10;

  typedef enum {MIX_ZERO, MIX_SMALL, MIX_FULL, MIX_MAX, MIX_MIN, MIX_CORNERS} gain_mix_t;
  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

  // One sensor sample and one set of controller outputs, index 0 is the x axis.
  typedef struct packed {
    logic [2:0][SIG_W-1:0] angle;
    logic [2:0][SIG_W-1:0] rate;
  } sample_t;

  typedef struct packed {
    logic [2:0][DRIVE_W-1:0] drive;
    logic [2:0][SIG_W-1:0]   target;
  } ctrl_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  sig_t   angle_x = '0;
  sig_t   angle_y = '0;
  sig_t   angle_z = '0;
  sig_t   rate_x = '0;
  sig_t   rate_y = '0;
  sig_t   rate_z = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  drive_t drive_x;
  drive_t drive_y;
  drive_t drive_z;
  sig_t   rate_target_x;
  sig_t   rate_target_y;
  sig_t   rate_target_z;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  reg_t   cfg_data = '0;

  // Pending sensor samples and the controller outputs predicted for accepted ones.
  sample_t sample_q[$];
  ctrl_t   ctrl_out_q[$];

  // Mirror of the register file and of the loop state; loops 0..2 are outer, 3..5 inner.
  reg_t   ctrl_regs [NUM_REGS];
  longint integ_sum [6];
  longint last_err  [6];

  int fail_count   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  logic in_fire = 1'b0;

  cascaded_pid_three_axis_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .angle_x       (angle_x),
    .angle_y       (angle_y),
    .angle_z       (angle_z),
    .rate_x        (rate_x),
    .rate_y        (rate_y),
    .rate_z        (rate_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_x       (drive_x),
    .drive_y       (drive_y),
    .drive_z       (drive_z),
    .rate_target_x (rate_target_x),
    .rate_target_y (rate_target_y),
    .rate_target_z (rate_target_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lim_lo, longint lim_hi);
    if (v > lim_hi) begin
      return lim_hi;
    end else if (v < lim_lo) begin
      return lim_lo;
    end
    return v;
  endfunction

  // Signed Q8.8 field k of a packed register.
  function automatic longint gain_of(reg_t r, int k);
    gain_t g;
    g = r[k*GAIN_W +: GAIN_W];
    return g;
  endfunction

  function automatic longint gain_mul(longint g, longint e);
    return clip(g * e, -PROD_CAP, PROD_CAP);
  endfunction

  function automatic longint sp_q16(int axis);
    return gain_of(ctrl_regs[REG_SETPOINTS], axis) * (64'sd1 << (SIG_FRAC - GAIN_FRAC));
  endfunction

  // One PID loop: the sum always accumulates, the integral term only inside the band.
  function automatic longint pid_update(int loop, longint err);
    reg_t   gains;
    longint lim;
    longint acc;
    gains = ctrl_regs[loop + 1];
    lim = (loop < 3) ? OUTER_SUM_LIM : INNER_SUM_LIM;
    integ_sum[loop] = clip(integ_sum[loop] + err, -lim, lim);
    acc = 2 * gain_mul(gain_of(gains, FLD_KP), err)
        + 2 * gain_mul(gain_of(gains, FLD_KD), err - last_err[loop]);
    if (err <= SEP_BAND && err >= -SEP_BAND) begin
      acc += gain_mul(gain_of(gains, FLD_KI), integ_sum[loop]);
    end
    last_err[loop] = err;
    return acc >>> (GAIN_FRAC + 1);
  endfunction

  // Outer angle loop feeds the inner rate loop on each axis.
  function automatic ctrl_t cascade_step(sample_t s);
    ctrl_t  r;
    longint e_out;
    longint tgt;
    longint e_in;
    longint drv;
    for (int a = 0; a < 3; a++) begin
      e_out = clip(sp_q16(a) - longint'($signed(s.angle[a])), SIG_LO, SIG_HI);
      tgt   = clip(pid_update(a, e_out), SIG_LO, SIG_HI);
      e_in  = clip(tgt - longint'($signed(s.rate[a])), SIG_LO, SIG_HI);
      drv   = clip(pid_update(a + 3, e_in), -DRIVE_SAT, DRIVE_SAT);
      r.drive[a]  = drv[DRIVE_W-1:0];
      r.target[a] = tgt[SIG_W-1:0];
    end
    return r;
  endfunction

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sample_t mk_sample(longint ax, longint ay, longint az,
                                        longint rx, longint ry, longint rz);
    sample_t s;
    s.angle[0] = ax[SIG_W-1:0];
    s.angle[1] = ay[SIG_W-1:0];
    s.angle[2] = az[SIG_W-1:0];
    s.rate[0]  = rx[SIG_W-1:0];
    s.rate[1]  = ry[SIG_W-1:0];
    s.rate[2]  = rz[SIG_W-1:0];
    return s;
  endfunction

  // Mostly samples close to the setpoint so that the integral band and clamps are
  // exercised, plus moderate errors, raw noise and corner values.
  function automatic sample_t make_random_sample();
    sample_t s;
    int      style;
    longint  v;
    style = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      if (style < 55) begin
        v = sp_q16(a) - rand_span(4000);
        s.angle[a] = v[SIG_W-1:0];
        s.rate[a]  = SIG_W'(rand_span(4000));
      end else if (style < 75) begin
        v = sp_q16(a) - rand_span(64'sd1 << 20);
        s.angle[a] = v[SIG_W-1:0];
        s.rate[a]  = SIG_W'(rand_span(64'sd1 << 20));
      end else if (style < 92) begin
        s.angle[a] = $urandom;
        s.rate[a]  = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: s.angle[a] = SIG_MAX;
          1: s.angle[a] = SIG_MIN;
          2: s.angle[a] = '0;
          default: s.angle[a] = '1;
        endcase
        case ($urandom_range(0, 3))
          0: s.rate[a] = SIG_MAX;
          1: s.rate[a] = SIG_MIN;
          2: s.rate[a] = '0;
          default: s.rate[a] = '1;
        endcase
      end
    end
    return s;
  endfunction

  function automatic reg_t make_reg(gain_mix_t mix);
    reg_t  r;
    gain_t g;
    for (int k = 0; k < 3; k++) begin
      case (mix)
        MIX_ZERO:  g = '0;
        MIX_SMALL: g = gain_t'(rand_span(512));
        MIX_FULL:  g = gain_t'($urandom);
        MIX_MAX:   g = 16'sh7FFF;
        MIX_MIN:   g = 16'sh8000;
        default: begin
          case ($urandom_range(0, 4))
            0: g = 16'sh7FFF;
            1: g = 16'sh8000;
            2: g = '0;
            3: g = 16'sh0100;
            default: g = gain_t'($urandom);
          endcase
        end
      endcase
      r[k*GAIN_W +: GAIN_W] = g;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with
  // cfg_valid still high, so that back-to-back writes follow without a gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, reg_t data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Every sample yields one result, so an empty prediction queue means the block is idle.
  task automatic wait_quiet();
    @(posedge clk);
    while (sample_q.size() != 0 || in_valid || ctrl_out_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic compare_field(string what, int axis, longint want, longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s[%0d] mismatch: expected %0d, got %0d",
                 $realtime, what, axis, want, got);
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps, some gaps empty.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    sample_t s;
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s = sample_q.pop_front();
        angle_x  <= s.angle[0];
        angle_y  <= s.angle[1];
        angle_z  <= s.angle[2];
        rate_x   <= s.rate[0];
        rate_y   <= s.rate[1];
        rate_z   <= s.rate[2];
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: changing ready patterns, and now and then a long hold-off while the
  // sender still has plenty queued, so that the block backs up into its input.
  ready_mode_t ready_mode   = RDY_ALWAYS;
  int          mode_left    = 0;
  int          hold_left    = 0;
  int          next_hold_at = 200;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (results_seen >= next_hold_at && sample_q.size() > 20) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = next_hold_at + 700;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mode = RDY_ALWAYS;
          1: ready_mode = RDY_COIN;
          2: ready_mode = RDY_SPARSE;
          default: ready_mode = RDY_TOGGLE;
        endcase
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left = mode_left - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:    out_ready <= ~out_ready;
      endcase
    end
  end

  // Observe every transfer: update the register mirror, predict, and check results.
  always @(posedge clk) begin
    sample_t seen;
    ctrl_t   want;
    ctrl_t   got;
    if (rst) begin
      foreach (ctrl_regs[i]) ctrl_regs[i] = '0;
      ctrl_regs[REG_SETPOINTS] = SP_AT_RESET;
      foreach (integ_sum[i]) begin
        integ_sum[i] = 0;
        last_err[i]  = 0;
      end
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
        ctrl_regs[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        seen.angle[0] = angle_x;
        seen.angle[1] = angle_y;
        seen.angle[2] = angle_z;
        seen.rate[0]  = rate_x;
        seen.rate[1]  = rate_y;
        seen.rate[2]  = rate_z;
        ctrl_out_q.push_back(cascade_step(seen));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (ctrl_out_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result transfer with no sample outstanding", $realtime);
          end
        end else begin
          want = ctrl_out_q.pop_front();
          got.drive[0]  = drive_x;
          got.drive[1]  = drive_y;
          got.drive[2]  = drive_z;
          got.target[0] = rate_target_x;
          got.target[1] = rate_target_y;
          got.target[2] = rate_target_z;
          for (int a = 0; a < 3; a++) begin
            compare_field("drive", a, $signed(want.drive[a]), $signed(got.drive[a]));
            compare_field("rate_target", a, $signed(want.target[a]), $signed(got.target[a]));
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset defaults, a directed set, then random phases under several settings.
  initial begin
    longint    near_err [5] = '{0, 3276, -3276, 3277, -3277};
    gain_mix_t sp_mix;
    gain_mix_t g_mix;
    longint    d;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains are zero, so every output must be zero whatever the inputs.
    sample_q.push_back(mk_sample(0, 0, 0, 0, 0, 0));
    sample_q.push_back(mk_sample(SIG_HI, SIG_HI, SIG_HI, SIG_HI, SIG_HI, SIG_HI));
    sample_q.push_back(mk_sample(SIG_LO, SIG_LO, SIG_LO, SIG_LO, SIG_LO, SIG_LO));
    wait_quiet();

    // Setpoints x = 1.0, y = -1.0, z = 0 with moderate gains.
    write_reg(REG_SETPOINTS, {16'h0000, 16'hFF00, 16'h0100});
    for (int i = REG_OUTER_X; i <= REG_OUTER_Z; i++) begin
      write_reg(CFG_IDX_W'(i), {16'h0080, 16'h0100, 16'h0200});
    end
    for (int i = REG_INNER_X; i <= REG_INNER_Z; i++) begin
      write_reg(CFG_IDX_W'(i), {16'h0040, 16'h0200, 16'h0100});
    end
    cfg_valid <= 1'b0;

    // Errors on both sides of the integral separation band.
    foreach (near_err[k]) begin
      d = near_err[k];
      sample_q.push_back(mk_sample(sp_q16(0) - d, sp_q16(1) - d, sp_q16(2) - d, 0, 0, 0));
    end
    // Saturated errors, rate targets and drives.
    sample_q.push_back(mk_sample(SIG_HI, SIG_HI, SIG_HI, SIG_HI, SIG_HI, SIG_HI));
    sample_q.push_back(mk_sample(SIG_LO, SIG_LO, SIG_LO, SIG_LO, SIG_LO, SIG_LO));
    sample_q.push_back(mk_sample(SIG_LO, SIG_LO, SIG_LO, SIG_HI, SIG_HI, SIG_HI));
    sample_q.push_back(mk_sample(SIG_HI, SIG_HI, SIG_HI, SIG_LO, SIG_LO, SIG_LO));
    // A huge error drives each sum into its clamp, a small one then uses the clamped sum.
    sample_q.push_back(mk_sample(SIG_LO, SIG_LO, SIG_LO, 0, 0, 0));
    sample_q.push_back(mk_sample(sp_q16(0) - 1000, sp_q16(1) - 1000, sp_q16(2) - 1000, 0, 0, 0));
    sample_q.push_back(mk_sample(SIG_HI, SIG_HI, SIG_HI, 0, 0, 0));
    sample_q.push_back(mk_sample(sp_q16(0) + 1000, sp_q16(1) + 1000, sp_q16(2) + 1000, 0, 0, 0));
    // On target in angle, extreme rates.
    sample_q.push_back(mk_sample(sp_q16(0), sp_q16(1), sp_q16(2), SIG_HI, SIG_HI, SIG_HI));
    sample_q.push_back(mk_sample(sp_q16(0), sp_q16(1), sp_q16(2), SIG_LO, SIG_LO, SIG_LO));
    wait_quiet();

    // A write to the unused index must leave every register unchanged.
    write_reg(CFG_IDX_UNUSED, '1);
    cfg_valid <= 1'b0;
    sample_q.push_back(mk_sample(sp_q16(0) - 1000, sp_q16(1) - 1000, sp_q16(2) - 1000,
                                 500, -500, 0));
    sample_q.push_back(mk_sample(sp_q16(0) + 2000, sp_q16(1) + 2000, sp_q16(2) + 2000,
                                 -500, 500, 0));
    wait_quiet();

    // Random phases, the first ones at the extremes of the register fields.
    for (int p = 0; p < 11; p++) begin
      case (p)
        0: begin
          sp_mix = MIX_MAX;
          g_mix  = MIX_MAX;
        end
        1: begin
          sp_mix = MIX_MIN;
          g_mix  = MIX_MIN;
        end
        2: begin
          sp_mix = MIX_FULL;
          g_mix  = MIX_ZERO;
        end
        default: begin
          sp_mix = ($urandom_range(0, 1) == 0) ? MIX_SMALL : MIX_FULL;
          case ($urandom_range(0, 4))
            0, 1, 2: g_mix = MIX_SMALL;
            3:       g_mix = MIX_FULL;
            default: g_mix = MIX_CORNERS;
          endcase
        end
      endcase
      write_reg(REG_SETPOINTS, make_reg(sp_mix));
      for (int i = REG_OUTER_X; i <= REG_INNER_Z; i++) begin
        write_reg(CFG_IDX_W'(i), make_reg(g_mix));
      end
      cfg_valid <= 1'b0;
      repeat (128) sample_q.push_back(make_random_sample());
      wait_quiet();
    end

    // Allow for any stray result beyond the block's latency.
    repeat (60) @(posedge clk);
    if (fail_count == 0 && ctrl_out_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
